@@ rtl/mine_neighbor_count_3x3_unit_defines.svh @@
// assertion macros for the mine neighbor count unit
// included by the top level only; no other dependencies
`ifndef MINE_NEIGHBOR_COUNT_3X3_UNIT_DEFINES_SVH
`define MINE_NEIGHBOR_COUNT_3X3_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define MNC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define MNC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/mnc_pkg.sv @@
// shared widths and controller/datapath interface types
// no dependencies
package mnc_pkg;

  localparam int COL_W    = 6;
  localparam int ROW_W    = 12;
  localparam int CNT_W    = 4;
  localparam int CFG_W    = 12;
  localparam int CFG_A_W  = 1;
  localparam int IN_DW    = 8;
  localparam int OUT_DW   = 8;

  // configuration register indexes
  localparam logic [CFG_A_W-1:0] REG_GRID_COLS = 1'd0;
  localparam logic [CFG_A_W-1:0] REG_GRID_ROWS = 1'd1;

  // commands from the controller to the datapath
  typedef struct packed {
    logic accept;      // take the input cell into the line buffer
    logic load_upper;  // report column starts at the first upper-row report
    logic job_clear;   // report column back to zero for the final-row flush
    logic job_inc;     // next report column
    logic emit;        // load one result into the output register
    logic emit_flush;  // result belongs to the final row of the grid
    logic emit_last;   // result is the last one caused by this request
    logic commit;      // advance position and rotate lines after the request
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic has_a;       // request reports the cell up-left
    logic has_b;       // request reports the cell straight up (row end)
    logic has_f;       // request closes the grid
    logic job_is_c;    // report column equals the current column
    logic job_is_last; // report column is the last column
    logic slot_free;   // output register can take a result this cycle
  } sts_t;

endpackage

@@ rtl/mnc_ctrl.sv @@
// controller state machine: sequences the reports of one request
// depends on mnc_pkg for the command and status types
module mnc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  mnc_pkg::sts_t sts,
  output mnc_pkg::cmd_t cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_UPPER = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       pend_b_r, pend_b_nxt;
  logic       pend_f_r, pend_f_nxt;
  logic       upper_done;

  assign in_tready  = (state_r == S_IDLE);
  assign upper_done = sts.job_is_c || !pend_b_r;

  // next state and commands
  always_comb begin
    state_nxt  = state_r;
    pend_b_nxt = pend_b_r;
    pend_f_nxt = pend_f_r;
    cmd        = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          pend_b_nxt = sts.has_b;
          pend_f_nxt = sts.has_f;
          if (sts.has_a || sts.has_b) begin
            cmd.load_upper = 1'b1;
            state_nxt      = S_UPPER;
          end else if (sts.has_f) begin
            cmd.job_clear = 1'b1;
            state_nxt     = S_FLUSH;
          end else begin
            cmd.commit = 1'b1;
          end
        end
      end
      S_UPPER: begin
        if (sts.slot_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = upper_done && !pend_f_r;
          if (!upper_done) begin
            cmd.job_inc = 1'b1;
          end else if (pend_f_r) begin
            cmd.job_clear = 1'b1;
            state_nxt     = S_FLUSH;
          end else begin
            cmd.commit = 1'b1;
            state_nxt  = S_IDLE;
          end
        end
      end
      S_FLUSH: begin
        if (sts.slot_free) begin
          cmd.emit       = 1'b1;
          cmd.emit_flush = 1'b1;
          cmd.emit_last  = sts.job_is_last;
          if (sts.job_is_last) begin
            cmd.commit = 1'b1;
            state_nxt  = S_IDLE;
          end else begin
            cmd.job_inc = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      pend_b_r <= 1'b0;
      pend_f_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      pend_b_r <= pend_b_nxt;
      pend_f_r <= pend_f_nxt;
    end
  end

endmodule

@@ rtl/mnc_dp.sv @@
// datapath: configuration registers, three line buffers, position,
// neighbor counter and output register; depends on mnc_pkg
module mnc_dp #(
  parameter int MAX_COLS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [mnc_pkg::CFG_A_W-1:0]  cfg_addr,
  input  logic [mnc_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic                         in_bit,
  input  mnc_pkg::cmd_t                cmd,
  output mnc_pkg::sts_t                sts,
  input  logic                         out_tready,
  output logic                         out_tvalid,
  output logic [mnc_pkg::OUT_DW-1:0]   out_tdata,
  output logic                         out_tlast
);

  localparam int LW = MAX_COLS;
  localparam int IW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam logic [mnc_pkg::COL_W-1:0] MAX_C = mnc_pkg::COL_W'(MAX_COLS);

  logic [mnc_pkg::COL_W-1:0] grid_cols_r;
  logic [mnc_pkg::ROW_W-1:0] grid_rows_r;
  logic [mnc_pkg::COL_W-1:0] cols_now, cols_m1;
  logic [mnc_pkg::ROW_W-1:0] rows_m1;

  logic [LW-1:0] l0_r, l1_r, l2_r, l0_nxt, l1_nxt, l2_nxt;
  logic [mnc_pkg::COL_W-1:0] col_r, col_nxt, job_r, job_nxt;
  logic [mnc_pkg::ROW_W-1:0] row_r, row_nxt;

  logic                      off_grid, lre_e;
  logic [LW-1:0]             l0_e, l1_e, l2_e, l2_w;
  logic [mnc_pkg::COL_W-1:0] c_e;
  logic [mnc_pkg::ROW_W-1:0] r_e;
  logic [LW-1:0]             b_l0, b_l1, b_l2;
  logic [mnc_pkg::COL_W-1:0] b_c;
  logic [mnc_pkg::ROW_W-1:0] b_r;

  logic [LW-1:0]             col_mask, up_v, mid_v, dn_v;
  logic [mnc_pkg::ROW_W-1:0] rep_row;
  logic [mnc_pkg::COL_W-1:0] k_lo, k_hi;
  logic [mnc_pkg::CNT_W-1:0] cnt;
  logic                      is_mine, row_end, frame_end;

  logic                       out_valid_r, out_valid_nxt;
  logic [mnc_pkg::OUT_DW-1:0] out_data_r;
  logic                       out_last_r;

  // flag at a column; columns past the buffer (including the one left of zero) read as empty
  function automatic logic bit_at(input logic [LW-1:0] v,
                                  input logic [mnc_pkg::COL_W-1:0] idx);
    logic b;
    b = 1'b0;
    if (idx < MAX_C) begin
      b = v[idx[IW-1:0]];
    end
    return b;
  endfunction

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_cols_r <= mnc_pkg::COL_W'(1);
      grid_rows_r <= mnc_pkg::ROW_W'(1);
    end else if (cfg_we) begin
      case (cfg_addr)
        mnc_pkg::REG_GRID_COLS: grid_cols_r <= cfg_wdata[mnc_pkg::COL_W-1:0];
        mnc_pkg::REG_GRID_ROWS: grid_rows_r <= cfg_wdata[mnc_pkg::ROW_W-1:0];
        default: ;
      endcase
    end
  end

  // effective grid size: zero counts as one, columns capped at the buffer width
  always_comb begin
    if (grid_cols_r == '0) begin
      cols_now = mnc_pkg::COL_W'(1);
    end else if (grid_cols_r > MAX_C) begin
      cols_now = MAX_C;
    end else begin
      cols_now = grid_cols_r;
    end
    cols_m1 = cols_now - mnc_pkg::COL_W'(1);
    rows_m1 = (grid_rows_r == '0) ? '0 : grid_rows_r - mnc_pkg::ROW_W'(1);
  end

  // position after a possible restart when the grid shrank under it
  assign off_grid = (col_r > cols_m1) || (row_r > rows_m1);
  assign c_e      = off_grid ? '0 : col_r;
  assign r_e      = off_grid ? '0 : row_r;
  assign l0_e     = off_grid ? '0 : l0_r;
  assign l1_e     = off_grid ? '0 : l1_r;
  assign l2_e     = off_grid ? '0 : l2_r;
  assign l2_w     = (l2_e & ~(LW'(1) << c_e)) | (LW'(in_bit) << c_e);
  assign lre_e    = (c_e == cols_m1);

  // what the incoming request will report
  assign sts.has_a       = (r_e != '0) && (c_e != '0);
  assign sts.has_b       = (r_e != '0) && lre_e;
  assign sts.has_f       = lre_e && (r_e == rows_m1);
  assign sts.job_is_c    = (job_r == col_r);
  assign sts.job_is_last = (job_r == cols_m1);
  assign sts.slot_free   = !out_valid_r || out_tready;

  // line buffers and position: write the cell, then advance on commit
  always_comb begin
    b_l0 = cmd.accept ? l0_e : l0_r;
    b_l1 = cmd.accept ? l1_e : l1_r;
    b_l2 = cmd.accept ? l2_w : l2_r;
    b_c  = cmd.accept ? c_e  : col_r;
    b_r  = cmd.accept ? r_e  : row_r;
    l0_nxt  = b_l0;
    l1_nxt  = b_l1;
    l2_nxt  = b_l2;
    col_nxt = b_c;
    row_nxt = b_r;
    if (cmd.commit) begin
      if (b_c == cols_m1 && b_r == rows_m1) begin
        l0_nxt  = '0;
        l1_nxt  = '0;
        l2_nxt  = '0;
        col_nxt = '0;
        row_nxt = '0;
      end else if (b_c == cols_m1) begin
        l0_nxt  = b_l1;
        l1_nxt  = b_l2;
        l2_nxt  = '0;
        col_nxt = '0;
        row_nxt = b_r + mnc_pkg::ROW_W'(1);
      end else begin
        col_nxt = b_c + mnc_pkg::COL_W'(1);
      end
    end
  end

  // report column counter
  always_comb begin
    job_nxt = job_r;
    if (cmd.load_upper) begin
      job_nxt = sts.has_a ? c_e - mnc_pkg::COL_W'(1) : c_e;
    end else if (cmd.job_clear) begin
      job_nxt = '0;
    end else if (cmd.job_inc) begin
      job_nxt = job_r + mnc_pkg::COL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l0_r  <= '0;
      l1_r  <= '0;
      l2_r  <= '0;
      col_r <= '0;
      row_r <= '0;
    end else begin
      l0_r  <= l0_nxt;
      l1_r  <= l1_nxt;
      l2_r  <= l2_nxt;
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
  end

  // neighbor window: upper reports sit on the row above, flush reports on the final row
  always_comb begin
    col_mask = (LW'(1) << cols_now) - LW'(1);
    if (cmd.emit_flush) begin
      up_v    = (row_r != '0) ? l1_r : '0;
      mid_v   = l2_r;
      dn_v    = '0;
      rep_row = row_r;
    end else begin
      up_v    = (row_r > mnc_pkg::ROW_W'(1)) ? l0_r : '0;
      mid_v   = l1_r;
      dn_v    = l2_r;
      rep_row = row_r - mnc_pkg::ROW_W'(1);
    end
    up_v  = up_v & col_mask;
    mid_v = mid_v & col_mask;
    dn_v  = dn_v & col_mask;
  end

  // count the eight neighbors
  assign k_lo    = job_r - mnc_pkg::COL_W'(1);
  assign k_hi    = job_r + mnc_pkg::COL_W'(1);
  assign is_mine = bit_at(mid_v, job_r);
  assign cnt = mnc_pkg::CNT_W'(bit_at(up_v, k_lo))  + mnc_pkg::CNT_W'(bit_at(up_v, job_r))
             + mnc_pkg::CNT_W'(bit_at(up_v, k_hi))  + mnc_pkg::CNT_W'(bit_at(mid_v, k_lo))
             + mnc_pkg::CNT_W'(bit_at(mid_v, k_hi)) + mnc_pkg::CNT_W'(bit_at(dn_v, k_lo))
             + mnc_pkg::CNT_W'(bit_at(dn_v, job_r)) + mnc_pkg::CNT_W'(bit_at(dn_v, k_hi));
  assign row_end   = (job_r == cols_m1);
  assign frame_end = row_end && (rep_row == rows_m1);

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r <= {1'b0, frame_end, row_end,
                     is_mine ? mnc_pkg::CNT_W'(0) : cnt, is_mine};
      out_last_r <= cmd.emit_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

@@ rtl/mine_neighbor_count_3x3_unit.sv @@
// Mine neighbor counter over a raster stream of mine flags.
// Input: in_tdata[0] is one cell's mine flag, cells in raster order.
// Output: per reported cell, mine flag or count of mined neighbors (0..8),
// row and grid end marks; out_tlast marks the last result of a request.
// Config: cfg_addr 0 = column count (1..MAX_COLS), 1 = row count.
// A cell at row r, column c reports the cell up-left of it; the last cell
// of a row also reports the cell straight up, and the last cell of the
// grid then reports the whole final row and starts a new grid.
// Timing: one result per cycle leaves through the output register while the
// receiver is ready; the input is held from when a request is taken until
// its last result is loaded. A request gives n results: 0 on the first row
// and in column 0, 1 mid-row, 2 at a row end, up to 2 + columns at the grid
// end. The single output register and the one-cell-per-cycle neighbor
// counter set this rate. A stalled receiver holds the result and the
// sequence; no result is lost. Reset (rst_n low, synchronous) clears the
// line buffers and position and sets both counts to one; no clearing pass
// is needed.
module mine_neighbor_count_3x3_unit #(
  parameter int MAX_COLS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // configuration write port
  input  logic                         cfg_we,
  input  logic [mnc_pkg::CFG_A_W-1:0]  cfg_addr,
  input  logic [mnc_pkg::CFG_W-1:0]    cfg_wdata,
  // input cells
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [mnc_pkg::IN_DW-1:0]    in_tdata,   // [0] cell_is_mine, [7:1] zero
  // results
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [mnc_pkg::OUT_DW-1:0]   out_tdata,  // [0] result_is_mine, [4:1] mine_count,
                                                   // [5] row_end, [6] frame_end, [7] zero
  output logic                         out_tlast   // last_of_run
);

`include "mine_neighbor_count_3x3_unit_defines.svh"

  mnc_pkg::cmd_t cmd;
  mnc_pkg::sts_t sts;

  mnc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mnc_dp #(
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_bit     (in_tdata[0]),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // result consistency checks
  `MNC_ASSERT_NOW(a_count_range, clk, rst_n, out_tvalid, out_tdata[4:1] <= 4'd8, "count above eight")
  `MNC_ASSERT_NOW(a_mine_no_count, clk, rst_n, out_tvalid && out_tdata[0], out_tdata[4:1] == 4'd0, "mine with count")
  `MNC_ASSERT_NOW(a_frame_row_end, clk, rst_n, out_tvalid && out_tdata[6], out_tdata[5], "grid end off row end")
  `MNC_ASSERT_NOW(a_frame_last, clk, rst_n, out_tvalid && out_tdata[6], out_tlast, "grid end not last result")

endmodule
